>>> rtl/twra_pkg.sv
// ----------------------------------------------------------------------------
// twra_pkg
// Shared constants for the time-window ring average core.
// ----------------------------------------------------------------------------
`default_nettype none

package twra_pkg;

	localparam int CAPACITY   = 25;
	localparam int COUNT_BITS = 16;

	localparam int WINDOW_W = 62;
	localparam int TIME_W   = 63;
	localparam int AVG_W    = 23;
	localparam int USED_W   = 5;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 62'd250000000;

	localparam logic REG_WINDOW = 1'b0;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

endpackage

`default_nettype wire

>>> rtl/twra_if.sv
// ----------------------------------------------------------------------------
// twra_if
// Valid/ready channels for sample/query items and average results.
// ----------------------------------------------------------------------------
`default_nettype none

interface twra_in_if #(
	parameter int COUNT_BITS = twra_pkg::COUNT_BITS
);
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [twra_pkg::TIME_W-1:0]   time_ns;
	logic [COUNT_BITS-1:0]         run_count;

	modport source (output valid, output kind, output time_ns, output run_count,
		input ready);
	modport sink (input valid, input kind, input time_ns, input run_count,
		output ready);
endinterface

interface twra_out_if;
	logic                          valid;
	logic                          ready;
	logic [twra_pkg::AVG_W-1:0]    average_x100;
	logic [twra_pkg::USED_W-1:0]   samples_used;

	modport source (output valid, output average_x100, output samples_used,
		input ready);
	modport sink (input valid, input average_x100, input samples_used,
		output ready);
endinterface

`default_nettype wire

>>> rtl/twra_ram.sv
// ----------------------------------------------------------------------------
// twra_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module twra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/twra_div.sv
// ----------------------------------------------------------------------------
// twra_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module twra_div #(
	parameter int NUM_W = 8,
	parameter int DEN_W = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output      logic             done,
	output      logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

`default_nettype wire

>>> rtl/time_window_ring_average_core.sv
// ----------------------------------------------------------------------------
// time_window_ring_average_core
// Ring of timestamped run counts; a query averages the entries in the window.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    kind, time_ns, run_count
//   out_ch   out  valid/ready    average_x100, samples_used
//   apb      in   psel/penable   window_ns at byte address 0
//
// A sample is one RAM write and gives no result.
// After acceptance a query holds the input through the walk (k entries
// checked, one RAM read per cycle, none for an empty ring), the divider start
// state, the divide and the result load.
// Reset clears the ring pointers and loads the window reset value; ring
// contents need no clearing.
// Samples are taken while a result waits on out_ch; a finished query waits.
// ----------------------------------------------------------------------------
`default_nettype none

module time_window_ring_average_core #(
	parameter int CAPACITY   = twra_pkg::CAPACITY,
	parameter int COUNT_BITS = twra_pkg::COUNT_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [twra_pkg::PADDR_W-1:0] paddr,
	input  wire logic [twra_pkg::PDATA_W-1:0] pwdata,
	output      logic [twra_pkg::PDATA_W-1:0] prdata,
	output      logic                         pready,
	twra_in_if.sink                           in_ch,
	twra_out_if.source                        out_ch
);

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int FILL_W  = $clog2(CAPACITY + 1);
	localparam int SUM_W   = COUNT_BITS + FILL_W;
	localparam int NUM_W   = SUM_W + 7;
	localparam int ENTRY_W = twra_pkg::TIME_W + COUNT_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WALK  = 3'd1;
	localparam logic [2:0] ST_SCALE = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                    state_q;
	logic [twra_pkg::WINDOW_W-1:0] window_q;
	logic [IDX_W-1:0]              newest_q;
	logic [FILL_W-1:0]             filled_q;
	logic [IDX_W-1:0]              pos_q;
	logic                          pend_q;
	logic [63:0]                   limit_q;
	logic [SUM_W-1:0]              sum_q;
	logic [FILL_W-1:0]             used_q;
	logic                          out_valid_q;
	logic [twra_pkg::AVG_W-1:0]    avg_q;
	logic [twra_pkg::USED_W-1:0]   used_out_q;

	logic                          cfg_wr;
	logic                          in_take;
	logic                          full;
	logic [IDX_W-1:0]              wr_addr;
	logic                          wr_en;
	logic                          rd_en;
	logic [ENTRY_W-1:0]            rd_data;
	logic [twra_pkg::TIME_W-1:0]   rd_time;
	logic [COUNT_BITS-1:0]         rd_count;
	logic                          older;
	logic [FILL_W-1:0]             used_inc;
	logic [IDX_W-1:0]              pos_prev;
	logic [NUM_W-1:0]              div_num;
	logic                          div_start;
	logic                          div_done;
	logic [NUM_W-1:0]              div_quot;
	logic                          out_free;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[3] == twra_pkg::REG_WINDOW);
	assign prdata = (paddr[3] == twra_pkg::REG_WINDOW) ? {2'b00, window_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= twra_pkg::WINDOW_RESET;
		end else if (cfg_wr) begin
			window_q <= pwdata[twra_pkg::WINDOW_W-1:0];
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_take     = in_ch.valid && in_ch.ready;

	assign full    = (filled_q == FILL_W'(CAPACITY));
	assign wr_addr = !full ? IDX_W'(filled_q)
		: (newest_q == IDX_W'(CAPACITY - 1)) ? '0 : newest_q + IDX_W'(1);
	assign wr_en   = in_take && (in_ch.kind == twra_pkg::KIND_SAMPLE);
	assign rd_en   = (state_q == ST_WALK);

	twra_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ring (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata({in_ch.time_ns, in_ch.run_count}),
		.re   (rd_en),
		.raddr(pos_q),
		.rdata(rd_data)
	);

	assign rd_time  = rd_data[ENTRY_W-1 -: twra_pkg::TIME_W];
	assign rd_count = rd_data[COUNT_BITS-1:0];
	assign older    = $signed({1'b0, rd_time}) < $signed(limit_q);
	assign used_inc = used_q + FILL_W'(1);
	assign pos_prev = (pos_q == '0) ? IDX_W'(CAPACITY - 1) : pos_q - IDX_W'(1);

	assign div_num   = (NUM_W'(sum_q) << 6) + (NUM_W'(sum_q) << 5) + (NUM_W'(sum_q) << 2);
	assign div_start = (state_q == ST_SCALE);
	assign out_free  = !out_valid_q || out_ch.ready;

	twra_div #(
		.NUM_W(NUM_W),
		.DEN_W(FILL_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (used_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			newest_q    <= '0;
			filled_q    <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					pend_q <= 1'b0;
					if (wr_en) begin
						newest_q <= wr_addr;
						if (!full) begin
							filled_q <= filled_q + FILL_W'(1);
						end
					end else if (in_take) begin
						state_q <= (filled_q == '0) ? ST_SCALE : ST_WALK;
					end
				end
				ST_WALK: begin
					pend_q <= 1'b1;
					if (pend_q && (older || used_inc == filled_q)) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			limit_q <= {1'b0, in_ch.time_ns} - {2'b00, window_q};
			pos_q   <= newest_q;
			sum_q   <= '0;
			used_q  <= '0;
		end else if (state_q == ST_WALK) begin
			pos_q <= pos_prev;
			if (pend_q && !older) begin
				sum_q  <= sum_q + SUM_W'(rd_count);
				used_q <= used_inc;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			avg_q      <= (used_q == '0) ? '0 : twra_pkg::AVG_W'(div_quot);
			used_out_q <= twra_pkg::USED_W'(used_q);
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.average_x100 = avg_q;
	assign out_ch.samples_used = used_out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= FILL_W'(CAPACITY))
		else $error("fill count beyond ring capacity");

	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> !wr_en)
		else $error("ring write during walk");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK || state_q == ST_SCALE) |-> (used_q <= filled_q))
		else $error("walk used more entries than filled");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> out_valid_q)
		else $error("result not presented after divide");

endmodule

`default_nettype wire
